>>> hw/rtl/camt_pkg.sv
// Shared constants for the calibrated angle multiturn tracker.
`default_nettype none

package camt_pkg;

    // Angle word and correction table geometry
    localparam int ANGLE_W           = 12;
    localparam int ENTRY_INDEX_W     = 9;
    localparam int TABLE_ENTRIES_DEF = 512;

    // Angle thresholds for table unwrap and turn crossing
    localparam logic [ANGLE_W-1:0] ANGLE_MAX     = 12'd4095;
    localparam logic [ANGLE_W-1:0] QUARTER_LOW   = 12'd1024;
    localparam logic [ANGLE_W-1:0] QUARTER_HIGH  = 12'd3072;

    // Request codes
    localparam logic [1:0] REQ_SAMPLE = 2'd0;
    localparam logic [1:0] REQ_WRITE  = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;

    // Configuration register indexes
    localparam logic CFG_USE_CAL = 1'b0;

endpackage

`default_nettype wire

>>> hw/rtl/calibrated_angle_multiturn_tracker.sv
// An accepted transaction passes the table read, product, angle and position registers on its way to the output.
// One transaction per cycle while the output is not stalled; the position loop closes in the last stage.
// Stages: table read, interpolation multiplies, angle combine, position accumulate.
// Reset: pipeline empty, angle and position zero, calibration off.
// The correction table has no reset and must be written before calibration is on.
`default_nettype none

module calibrated_angle_multiturn_tracker #(
    parameter int TABLE_ENTRIES = camt_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // Request channel
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic [1:0]                           req_type,
    input  wire logic [camt_pkg::ANGLE_W-1:0]         sample_angle,
    input  wire logic [camt_pkg::ENTRY_INDEX_W-1:0]   entry_index,
    input  wire logic [camt_pkg::ANGLE_W-1:0]         entry_value,
    // Result channel
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic      [camt_pkg::ANGLE_W-1:0]         angle,
    output logic signed [31:0]                        relative_position,
    // Configuration port
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [2:0]                           paddr,
    input  wire logic [31:0]                          pwdata,
    output logic      [31:0]                          prdata,
    output logic                                      pready
);

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int PW = camt_pkg::ANGLE_W + IW;
    localparam int AW = camt_pkg::ANGLE_W;

    // ------------------------------------------------------------------
    // Configuration register
    logic use_cal_reg;
    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == camt_pkg::CFG_USE_CAL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_cal_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            use_cal_reg <= pwdata[0];
        end
    end

    assign prdata = (paddr[2] == camt_pkg::CFG_USE_CAL) ? {31'd0, use_cal_reg} : 32'd0;

    // ------------------------------------------------------------------
    // Stage valids and back-pressure chain
    logic s1_v_reg, s2_v_reg, s3_v_reg, out_v_reg;
    logic rdy1, rdy2, rdy3, rdy4;
    logic in_fire;

    assign rdy4     = !out_v_reg || out_ready;
    assign rdy3     = !s3_v_reg || rdy4;
    assign rdy2     = !s2_v_reg || rdy3;
    assign rdy1     = !s1_v_reg || rdy2;
    assign in_ready = rdy1;
    assign in_fire  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) s1_v_reg  <= in_fire;
            if (rdy2) s2_v_reg  <= s1_v_reg;
            if (rdy3) s3_v_reg  <= s2_v_reg;
            if (rdy4) out_v_reg <= s3_v_reg;
        end
    end

    assign out_valid = out_v_reg;

    // ------------------------------------------------------------------
    // Stage 0: inversion, segment index and weight, table access
    logic [AW-1:0] inv_angle;
    logic [PW-1:0] seg_pos;
    logic [IW-1:0] idx_lo;
    logic [IW-1:0] idx_hi;
    logic          tbl_wr;
    logic [AW-1:0] tbl_lo;
    logic [AW-1:0] tbl_hi;

    assign inv_angle = camt_pkg::ANGLE_MAX - sample_angle;
    assign seg_pos   = PW'(inv_angle) * PW'(TABLE_ENTRIES);
    assign idx_lo    = seg_pos[PW-1:AW];
    assign idx_hi    = (idx_lo == IW'(TABLE_ENTRIES - 1)) ? '0 : idx_lo + IW'(1);
    assign tbl_wr    = in_fire && (req_type == camt_pkg::REQ_WRITE)
                       && (32'(entry_index) < 32'(TABLE_ENTRIES));

    camt_corr_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_table (
        .clk        (clk),
        .wr_en      (tbl_wr),
        .wr_addr    (IW'(entry_index)),
        .wr_data    (entry_value),
        .rd_en      (in_fire),
        .rd_addr_lo (idx_lo),
        .rd_addr_hi (idx_hi),
        .rd_lo      (tbl_lo),
        .rd_hi      (tbl_hi)
    );

    logic [1:0]    s1_req_reg;
    logic [AW-1:0] s1_inv_reg;
    logic [AW-1:0] s1_frac_reg;

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_req_reg  <= req_type;
            s1_inv_reg  <= inv_angle;
            s1_frac_reg <= seg_pos[AW-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: unwrap upper entry across zero, weighted products
    logic [AW:0]   hi_unwrap;
    logic [AW:0]   w_lo;
    logic [2*AW:0] prod_lo;
    logic [2*AW:0] prod_hi;

    always_comb
    begin
        hi_unwrap = {1'b0, tbl_hi};
        if ((tbl_lo > camt_pkg::QUARTER_HIGH) && (tbl_hi < camt_pkg::QUARTER_LOW))
        begin
            hi_unwrap = {1'b1, tbl_hi};
        end
    end

    assign w_lo    = {1'b1, {AW{1'b0}}} - {1'b0, s1_frac_reg};
    assign prod_lo = (2*AW+1)'(tbl_lo) * (2*AW+1)'(w_lo);
    assign prod_hi = (2*AW+1)'(hi_unwrap) * (2*AW+1)'(s1_frac_reg);

    logic [1:0]    s2_req_reg;
    logic [AW-1:0] s2_inv_reg;
    logic [2*AW:0] s2_plo_reg;
    logic [2*AW:0] s2_phi_reg;

    always_ff @(posedge clk)
    begin
        if (rdy2 && s1_v_reg)
        begin
            s2_req_reg <= s1_req_reg;
            s2_inv_reg <= s1_inv_reg;
            s2_plo_reg <= prod_lo;
            s2_phi_reg <= prod_hi;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: sum, truncate, wrap below one turn (bits above the turn drop); raw angle when calibration is off
    logic [2*AW+1:0] interp_sum;
    logic [AW-1:0]   corr_angle;

    assign interp_sum = {1'b0, s2_plo_reg} + {1'b0, s2_phi_reg};
    assign corr_angle = interp_sum[2*AW-1:AW];

    logic [1:0]    s3_req_reg;
    logic [AW-1:0] s3_angle_reg;

    always_ff @(posedge clk)
    begin
        if (rdy3 && s2_v_reg)
        begin
            s3_req_reg   <= s2_req_reg;
            s3_angle_reg <= use_cal_reg ? corr_angle : s2_inv_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: turn crossing, saturating position accumulate
    logic [AW-1:0] prev_angle_reg, prev_angle_next;
    logic [31:0]   acc_reg, acc_next;
    logic [AW+1:0] cur_ext;
    logic [AW+1:0] step;
    logic [32:0]   acc_sum;
    logic          s3_fire;

    assign s3_fire = rdy4 && s3_v_reg;

    always_comb
    begin
        cur_ext = {2'b00, s3_angle_reg};
        if ((s3_angle_reg < camt_pkg::QUARTER_LOW) && (prev_angle_reg >= camt_pkg::QUARTER_HIGH))
        begin
            cur_ext = {2'b00, s3_angle_reg} + {2'b01, {AW{1'b0}}};
        end
        else if ((s3_angle_reg >= camt_pkg::QUARTER_HIGH)
                 && (prev_angle_reg < camt_pkg::QUARTER_LOW))
        begin
            cur_ext = {2'b00, s3_angle_reg} - {2'b01, {AW{1'b0}}};
        end
        step    = cur_ext - {2'b00, prev_angle_reg};
        acc_sum = {acc_reg[31], acc_reg} + {{(33-(AW+2)){step[AW+1]}}, step};

        prev_angle_next = prev_angle_reg;
        acc_next        = acc_reg;
        unique case (s3_req_reg)
            camt_pkg::REQ_SAMPLE:
            begin
                prev_angle_next = s3_angle_reg;
                if (acc_sum[32] != acc_sum[31])
                begin
                    acc_next = acc_sum[32] ? 32'h8000_0000 : 32'h7fff_ffff;
                end
                else
                begin
                    acc_next = acc_sum[31:0];
                end
            end
            camt_pkg::REQ_CLEAR:
            begin
                acc_next = 32'd0;
            end
            default:
            begin
                acc_next = acc_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_angle_reg <= '0;
            acc_reg        <= 32'd0;
        end
        else if (s3_fire)
        begin
            prev_angle_reg <= prev_angle_next;
            acc_reg        <= acc_next;
        end
    end

    // The tracked state is the output register
    assign angle             = prev_angle_reg;
    assign relative_position = acc_reg;

`ifndef NO_ASSERTIONS
    // State moves only when a transaction leaves the last stage
    assert property (@(posedge clk) disable iff (!rst_n)
        !s3_fire |=> ($stable(acc_reg) && $stable(prev_angle_reg)))
        else $error("tracker state changed without a completing transaction");

    // A clear request leaves the position at zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (s3_fire && (s3_req_reg == camt_pkg::REQ_CLEAR)) |=> (acc_reg == 32'd0))
        else $error("position not cleared");

    // Non-sample requests keep the last angle
    assert property (@(posedge clk) disable iff (!rst_n)
        (s3_fire && (s3_req_reg != camt_pkg::REQ_SAMPLE)) |=> $stable(prev_angle_reg))
        else $error("angle changed on a non-sample request");

    // A waiting result is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && !out_ready) |=> (out_v_reg && $stable(acc_reg)))
        else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/camt_corr_table.sv
// Correction table memory: one write port, two registered read ports.
`default_nettype none

module camt_corr_table #(
    parameter int TABLE_ENTRIES = camt_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  wr_en,
    input  wire logic [$clog2(TABLE_ENTRIES)-1:0]      wr_addr,
    input  wire logic [camt_pkg::ANGLE_W-1:0]          wr_data,
    input  wire logic                                  rd_en,
    input  wire logic [$clog2(TABLE_ENTRIES)-1:0]      rd_addr_lo,
    input  wire logic [$clog2(TABLE_ENTRIES)-1:0]      rd_addr_hi,
    output logic      [camt_pkg::ANGLE_W-1:0]          rd_lo,
    output logic      [camt_pkg::ANGLE_W-1:0]          rd_hi
);

    logic [camt_pkg::ANGLE_W-1:0] mem [TABLE_ENTRIES];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read ports, data held while the consumer stalls
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_lo <= mem[rd_addr_lo];
            rd_hi <= mem[rd_addr_hi];
        end
    end

endmodule

`default_nettype wire

>>> sim/calibrated_angle_multiturn_tracker_tb.sv
// Self-checking testbench for the calibrated angle multiturn tracker.
module calibrated_angle_multiturn_tracker_tb;

    // Field widths from the package
    localparam int ANGLE_W       = camt_pkg::ANGLE_W;
    localparam int ENTRY_INDEX_W = camt_pkg::ENTRY_INDEX_W;

    // Request code that the block ignores, and register addresses
    localparam logic [1:0] REQ_IGNORED    = 2'd3;
    localparam logic [2:0] USE_CAL_ADDR   = {camt_pkg::CFG_USE_CAL, 2'b00};
    localparam logic [2:0] UNMAPPED_ADDR  = 3'd4;

    localparam int     TABLE_SIZE     = camt_pkg::TABLE_ENTRIES_DEF;
    localparam int     FULL_TURN      = 4096;
    localparam longint POSITION_MAX   = 64'sd2147483647;
    localparam longint POSITION_MIN   = -64'sd2147483648;
    localparam int     TIMEOUT_CYCLES = 300000;
    localparam int     REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [ANGLE_W-1:0] angle;
        logic signed [31:0] position;
    } reading_t;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic [1:0]               req_type;
    logic [ANGLE_W-1:0]       sample_angle;
    logic [ENTRY_INDEX_W-1:0] entry_index;
    logic [ANGLE_W-1:0]       entry_value;
    logic                     out_valid;
    logic                     out_ready;
    logic [ANGLE_W-1:0]       angle;
    logic signed [31:0]       relative_position;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [2:0]               paddr;
    logic [31:0]              pwdata;
    logic [31:0]              prdata;
    logic                     pready;

    // Predicted block state
    logic [ANGLE_W-1:0] cal_table [TABLE_SIZE];
    logic [ANGLE_W-1:0] last_angle;
    logic signed [31:0] turn_position;
    logic               cal_on;
    reading_t           expected_readings [$];

    int error_count;
    int cycle_count;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_left;
    int sweep_angle;
    int spin_dir;

    calibrated_angle_multiturn_tracker DUT (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .req_type          (req_type),
        .sample_angle      (sample_angle),
        .entry_index       (entry_index),
        .entry_value       (entry_value),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .angle             (angle),
        .relative_position (relative_position),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Table interpolation on the low fraction bits, with unwrap across zero
    function automatic logic [ANGLE_W-1:0] corrected_angle(input logic [ANGLE_W-1:0] raw);
        int unsigned p;
        int unsigned idx;
        int unsigned frac;
        int unsigned nxt;
        int unsigned lo;
        int unsigned hi;
        int unsigned r;
        p    = int'(raw) * TABLE_SIZE;
        idx  = p >> ANGLE_W;
        frac = p & (FULL_TURN - 1);
        if (idx >= TABLE_SIZE)
            idx = TABLE_SIZE - 1;
        nxt = (idx + 1 < TABLE_SIZE) ? idx + 1 : 0;
        lo  = cal_table[idx];
        hi  = cal_table[nxt];
        if (lo > camt_pkg::QUARTER_HIGH && hi < camt_pkg::QUARTER_LOW)
            hi += FULL_TURN;
        r = (lo * (FULL_TURN - frac) + hi * frac) >> ANGLE_W;
        if (r > camt_pkg::ANGLE_MAX)
            r -= FULL_TURN;
        return r[ANGLE_W-1:0];
    endfunction

    // Update the predicted state for one accepted request and queue its reading
    task automatic track_request(input logic [1:0] kind, input logic [ANGLE_W-1:0] raw,
                                 input logic [ENTRY_INDEX_W-1:0] slot,
                                 input logic [ANGLE_W-1:0] value);
        logic [ANGLE_W-1:0] now_angle;
        longint             unwrapped;
        longint             prev_angle;
        longint             sum;
        reading_t           due;
        case (kind)
            camt_pkg::REQ_SAMPLE:
            begin
                now_angle = camt_pkg::ANGLE_MAX - raw;
                if (cal_on)
                    now_angle = corrected_angle(now_angle);
                unwrapped  = now_angle;
                prev_angle = last_angle;
                if (now_angle < camt_pkg::QUARTER_LOW && last_angle >= camt_pkg::QUARTER_HIGH)
                    unwrapped += FULL_TURN;
                else if (now_angle >= camt_pkg::QUARTER_HIGH
                         && last_angle < camt_pkg::QUARTER_LOW)
                    unwrapped -= FULL_TURN;
                sum = longint'(turn_position) + unwrapped - prev_angle;
                if (sum > POSITION_MAX)
                    sum = POSITION_MAX;
                if (sum < POSITION_MIN)
                    sum = POSITION_MIN;
                turn_position = sum[31:0];
                last_angle    = now_angle;
            end
            camt_pkg::REQ_WRITE:
            begin
                if (slot < TABLE_SIZE)
                    cal_table[slot] = value;
            end
            camt_pkg::REQ_CLEAR:
            begin
                turn_position = '0;
            end
            default:
            begin
            end
        endcase
        due.angle    = last_angle;
        due.position = turn_position;
        expected_readings = {expected_readings, due};
    endtask

    // Watch both channels and the register port; predict and check
    always @(posedge clk)
    begin : watch
        reading_t due;
        if (rst_n)
        begin
            if (psel && penable && pwrite && pready && paddr == USE_CAL_ADDR)
                cal_on = pwdata[0];
            if (in_valid && in_ready)
                track_request(req_type, sample_angle, entry_index, entry_value);
            if (out_valid && out_ready)
            begin
                if (expected_readings.size() == 0)
                begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display("unexpected transaction: angle %0d position %0d",
                                 angle, relative_position);
                end
                else
                begin
                    due = expected_readings.pop_front();
                    if (due.angle !== angle || due.position !== relative_position)
                    begin
                        error_count++;
                        if (error_count <= REPORT_LIMIT)
                            $display({"mismatch: expected angle %0d position %0d, ",
                                      "got angle %0d position %0d"},
                                     due.angle, due.position, angle, relative_position);
                    end
                end
            end
        end
    end

    // Receiver: random stalls, or a long hold-off when one is requested
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left--;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Run limit
    initial
    begin
        cycle_count = 0;
        while (cycle_count < TIMEOUT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    // Offer one request, with a random gap first; returns at the accepting edge
    task automatic offer_request(input logic [1:0] kind, input logic [ANGLE_W-1:0] raw,
                                 input logic [ENTRY_INDEX_W-1:0] slot,
                                 input logic [ANGLE_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        req_type     <= kind;
        sample_angle <= raw;
        entry_index  <= slot;
        entry_value  <= value;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Sample whose inverted angle is the one given
    task automatic offer_inverted(input int inv);
        offer_request(camt_pkg::REQ_SAMPLE, 12'(camt_pkg::ANGLE_MAX - inv),
                      9'($urandom), 12'($urandom));
    endtask

    task automatic offer_entry(input int slot, input int value);
        offer_request(camt_pkg::REQ_WRITE, 12'($urandom), 9'(slot), 12'(value));
    endtask

    // Stop offering and wait for every outstanding reading
    task automatic settle;
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_readings.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_register(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Upper bits are junk; only bit 0 matters
    task automatic set_calibration(input logic on);
        write_register(USE_CAL_ADDR, {31'($urandom), on});
    endtask

    // Raw path: extremes, every request kind, both turn crossings
    task automatic test_raw_directed;
        offer_request(camt_pkg::REQ_SAMPLE, '0, '0, '0);
        offer_request(camt_pkg::REQ_SAMPLE, camt_pkg::ANGLE_MAX, '1, '1);
        offer_inverted(1023);
        offer_inverted(3072);
        offer_inverted(1024);
        offer_inverted(3071);
        offer_inverted(3072);
        offer_inverted(1023);
        offer_inverted(4095);
        offer_inverted(0);
        offer_request(camt_pkg::REQ_CLEAR, '1, '1, '1);
        offer_inverted(2048);
        offer_request(REQ_IGNORED, '0, '1, '0);
        offer_entry(0, 0);
        offer_entry(TABLE_SIZE - 1, 4095);
        offer_entry(9'h155, 12'hAAA);
        offer_entry(9'h0AA, 12'h555);
        offer_inverted(500);
        offer_request(camt_pkg::REQ_CLEAR, '0, '0, '0);
        offer_inverted(3500);
        settle();
    endtask

    // Write every table entry: a rising or falling ramp with jitter and occasional random values
    task automatic test_table_fill(input bit falling);
        int base;
        int value;
        base = $urandom_range(4095);
        for (int i = 0; i < TABLE_SIZE; i++)
        begin
            value = falling ? base - i * 8 : base + i * 8;
            value += int'($urandom_range(30)) - 15;
            if ($urandom_range(19) == 0)
                value = $urandom_range(4095);
            offer_entry(i, value & (FULL_TURN - 1));
        end
        settle();
    endtask

    // Calibrated path: last entry wrap, unwrap across zero, falling segment
    task automatic test_calibrated_directed;
        set_calibration(1'b1);
        offer_entry(TABLE_SIZE - 1, 4000);
        offer_entry(0, 50);
        offer_entry(200, 3500);
        offer_entry(201, 100);
        offer_entry(300, 2000);
        offer_entry(301, 1900);
        offer_inverted(4088);
        offer_inverted(4091);
        offer_inverted(4095);
        offer_inverted(0);
        offer_inverted(1600);
        offer_inverted(1605);
        offer_inverted(1607);
        offer_inverted(2400);
        offer_inverted(2407);
        settle();
        // a write to an unmapped address must leave calibration on
        write_register(UNMAPPED_ADDR, 32'h0000_0000);
        offer_inverted(1603);
        offer_inverted(4093);
        settle();
    endtask

    // Mostly continuous rotation with random speed, plus jumps and other requests
    task automatic test_random_traffic(input int count);
        int pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 80)
            begin
                if ($urandom_range(15) == 0)
                    sweep_angle = $urandom_range(4095);
                else
                begin
                    if ($urandom_range(30) == 0)
                        spin_dir = -spin_dir;
                    sweep_angle += spin_dir * int'($urandom_range(900)) +
                                   int'($urandom_range(200)) - 100;
                end
                offer_request(camt_pkg::REQ_SAMPLE, 12'(sweep_angle),
                              9'($urandom), 12'($urandom));
            end
            else if (pick < 90)
                offer_entry($urandom_range(TABLE_SIZE - 1), $urandom_range(4095));
            else if (pick < 96)
                offer_request(camt_pkg::REQ_CLEAR, 12'($urandom), 9'($urandom),
                              12'($urandom));
            else
                offer_request(REQ_IGNORED, 12'($urandom), 9'($urandom), 12'($urandom));
        end
    endtask

    // Long receiver hold-off while requests keep coming, so the input stalls
    task automatic test_backpressure;
        @(posedge clk);
        hold_left = 300;
        test_random_traffic(16);
        settle();
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        req_type      <= camt_pkg::REQ_SAMPLE;
        sample_angle  <= '0;
        entry_index   <= '0;
        entry_value   <= '0;
        out_ready     <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        cal_on        = 1'b0;
        last_angle    = '0;
        turn_position = '0;
        error_count   = 0;
        hold_left     = 0;
        sweep_angle   = 0;
        spin_dir      = 1;
        send_idle_pct = 7;
        recv_idle_pct = 46;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_raw_directed();
        test_table_fill(1'b0);
        test_calibrated_directed();
        test_random_traffic(12);
        settle();
        test_backpressure();

        send_idle_pct = 46;
        recv_idle_pct = 7;
        set_calibration(1'b0);
        test_random_traffic(12);
        settle();
        set_calibration(1'b1);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(12);
        settle();

        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/camt_pkg.sv
hw/rtl/camt_corr_table.sv
hw/rtl/calibrated_angle_multiturn_tracker.sv
sim/calibrated_angle_multiturn_tracker_tb.sv
